// ===== rtl/core/sbl_pkg.sv =====
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types and constants of the serial boot image loader.
// ----------------------------------------------------------------------------
package sbl_pkg;

  localparam int unsigned PROGRESS_INTERVAL = 1024;
  localparam int unsigned PROG_W            = $clog2(PROGRESS_INTERVAL + 1);
  localparam int unsigned HEADER_BYTES      = 8;
  localparam int unsigned MAGIC_BYTES       = 4;
  localparam int unsigned HCNT_W            = $clog2(HEADER_BYTES);
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{8'h42, 8'h4F, 8'h4F, 8'h54};

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_ABORT = 1'b1
  } op_t;

  typedef enum logic {
    PH_HUNT = 1'b0,
    PH_LOAD = 1'b1
  } phase_t;

  typedef enum logic [2:0] {
    ST_HEADER     = 3'd0,
    ST_BAD_MAGIC  = 3'd1,
    ST_GOOD_MAGIC = 3'd2,
    ST_LOADING    = 3'd3,
    ST_ABORTED    = 3'd4
  } status_t;

  typedef struct packed {
    op_t                    op;
    logic [7:0]             data;
    logic [MAGIC_BYTES-1:0] magic_hit;
  } qent_t;

endpackage

// ===== rtl/core/sbl_if.sv =====
// ----------------------------------------------------------------------------
// sbl_in_if / sbl_out_if
// Valid/ready channels for received bytes and for loader results.
// ----------------------------------------------------------------------------
interface sbl_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface sbl_out_if;
  logic        valid;
  logic        ready;
  logic        mem_write;
  logic [31:0] mem_addr;
  logic [7:0]  mem_data;
  logic        progress;
  logic [2:0]  status;
  logic [31:0] image_size;
  logic        done_res;

  modport source (output valid, mem_write, mem_addr, mem_data, progress, status,
                  image_size, done_res, input ready);
  modport sink   (input valid, mem_write, mem_addr, mem_data, progress, status,
                  image_size, done_res, output ready);
endinterface

// ===== rtl/core/sbl_front.sv =====
// ----------------------------------------------------------------------------
// sbl_front
// Classifies each incoming item into an operation and precomputes magic hits.
// ----------------------------------------------------------------------------
module sbl_front (
  input  logic          in_valid,
  input  logic          in_command,
  input  logic [7:0]    in_rx_byte,
  output logic          in_ready,
  output logic          q_wr_valid,
  output sbl_pkg::qent_t q_wr_data,
  input  logic          q_wr_ready
);

  always_comb begin
    q_wr_data.op   = in_command ? sbl_pkg::OP_ABORT : sbl_pkg::OP_BYTE;
    q_wr_data.data = in_rx_byte;
    for (int i = 0; i < int'(sbl_pkg::MAGIC_BYTES); i++) begin
      q_wr_data.magic_hit[i] = (in_rx_byte == sbl_pkg::MAGIC[i]);
    end
  end

  assign q_wr_valid = in_valid;
  assign in_ready   = q_wr_ready;

endmodule

// ===== rtl/core/sbl_queue.sv =====
// ----------------------------------------------------------------------------
// sbl_queue
// Short FIFO between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module sbl_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  input  sbl_pkg::qent_t wr_data,
  output logic           wr_ready,
  output logic           rd_valid,
  output sbl_pkg::qent_t rd_data,
  input  logic           rd_ready
);

  localparam int unsigned PTR_W = $clog2(sbl_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(sbl_pkg::QUEUE_DEPTH + 1);

  sbl_pkg::qent_t   mem [sbl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CNT_W'(sbl_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(sbl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(sbl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/sbl_back.sv =====
// ----------------------------------------------------------------------------
// sbl_back
// Header parsing, image write generation and the registered result stage.
// ----------------------------------------------------------------------------
module sbl_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [31:0]    cfg_wr_data,
  input  logic           q_valid,
  input  sbl_pkg::qent_t q_data,
  output logic           q_ready,
  sbl_out_if.source      out_ch
);

  logic [31:0]                 load_base;
  sbl_pkg::phase_t             phase;
  sbl_pkg::phase_t             phase_next;
  logic [sbl_pkg::HCNT_W-1:0]  header_count;
  logic [sbl_pkg::HCNT_W-1:0]  header_count_next;
  logic                        magic_match;
  logic                        magic_match_next;
  logic [31:0]                 size_reg;
  logic [31:0]                 size_reg_next;
  logic [31:0]                 byte_offset;
  logic [31:0]                 byte_offset_next;
  logic [sbl_pkg::PROG_W-1:0]  prog_cnt;
  logic [sbl_pkg::PROG_W-1:0]  prog_cnt_next;

  logic                        fire;
  logic                        is_abort;
  logic                        last_header;
  logic                        magic_ok;
  logic [31:0]                 size_new;
  logic [31:0]                 offset_inc;
  logic                        load_done;

  logic                        r_write;
  logic [31:0]                 r_addr;
  logic [7:0]                  r_data;
  logic                        r_prog;
  sbl_pkg::status_t            r_status;
  logic [31:0]                 r_size;
  logic                        r_done;

  assign q_ready  = !out_ch.valid || out_ch.ready;
  assign fire     = q_valid && q_ready;
  assign is_abort = (q_data.op == sbl_pkg::OP_ABORT);

  assign last_header = (header_count == sbl_pkg::HCNT_W'(sbl_pkg::HEADER_BYTES - 1));
  assign offset_inc  = byte_offset + 32'd1;
  assign load_done   = (offset_inc == size_reg);

  always_comb begin
    magic_ok = magic_match;
    size_new = size_reg;
    if (!header_count[sbl_pkg::HCNT_W-1]) begin
      magic_ok = magic_match && q_data.magic_hit[header_count[1:0]];
    end else begin
      case (header_count[1:0])
        2'd0:    size_new[7:0]   = q_data.data;
        2'd1:    size_new[15:8]  = q_data.data;
        2'd2:    size_new[23:16] = q_data.data;
        default: size_new[31:24] = q_data.data;
      endcase
    end
  end

  always_comb begin
    phase_next = phase;
    if (is_abort) begin
      phase_next = sbl_pkg::PH_HUNT;
    end else begin
      case (phase)
        sbl_pkg::PH_HUNT: begin
          if (last_header && magic_ok && (size_new != 32'd0)) begin
            phase_next = sbl_pkg::PH_LOAD;
          end
        end
        sbl_pkg::PH_LOAD: begin
          if (load_done) begin
            phase_next = sbl_pkg::PH_HUNT;
          end
        end
        default: phase_next = sbl_pkg::PH_HUNT;
      endcase
    end
  end

  always_comb begin
    header_count_next = header_count;
    magic_match_next  = magic_match;
    size_reg_next     = size_reg;
    byte_offset_next  = byte_offset;
    prog_cnt_next     = prog_cnt;
    r_write           = 1'b0;
    r_addr            = '0;
    r_data            = '0;
    r_prog            = 1'b0;
    r_status          = sbl_pkg::ST_HEADER;
    r_size            = '0;
    r_done            = 1'b0;
    if (is_abort) begin
      header_count_next = '0;
      magic_match_next  = 1'b1;
      size_reg_next     = '0;
      byte_offset_next  = '0;
      prog_cnt_next     = '0;
      r_status          = sbl_pkg::ST_ABORTED;
    end else begin
      case (phase)
        sbl_pkg::PH_HUNT: begin
          if (!last_header) begin
            header_count_next = header_count + 1'b1;
            magic_match_next  = magic_ok;
            size_reg_next     = size_new;
            r_status          = sbl_pkg::ST_HEADER;
          end else begin
            header_count_next = '0;
            magic_match_next  = 1'b1;
            byte_offset_next  = '0;
            prog_cnt_next     = '0;
            if (!magic_ok) begin
              size_reg_next = '0;
              r_status      = sbl_pkg::ST_BAD_MAGIC;
            end else begin
              r_status = sbl_pkg::ST_GOOD_MAGIC;
              r_size   = size_new;
              if (size_new == 32'd0) begin
                size_reg_next = '0;
                r_done        = 1'b1;
              end else begin
                size_reg_next = size_new;
              end
            end
          end
        end
        sbl_pkg::PH_LOAD: begin
          r_write  = 1'b1;
          r_addr   = load_base + byte_offset;
          r_data   = q_data.data;
          r_prog   = (prog_cnt == '0);
          r_status = sbl_pkg::ST_LOADING;
          if (load_done) begin
            r_done            = 1'b1;
            header_count_next = '0;
            magic_match_next  = 1'b1;
            size_reg_next     = '0;
            byte_offset_next  = '0;
            prog_cnt_next     = '0;
          end else begin
            byte_offset_next = offset_inc;
            prog_cnt_next    = (prog_cnt == sbl_pkg::PROG_W'(sbl_pkg::PROGRESS_INTERVAL - 1))
                               ? '0 : prog_cnt + 1'b1;
          end
        end
        default: begin
          r_status = sbl_pkg::ST_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_base    <= '0;
      phase        <= sbl_pkg::PH_HUNT;
      header_count <= '0;
      magic_match  <= 1'b1;
      size_reg     <= '0;
      byte_offset  <= '0;
      prog_cnt     <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        load_base <= cfg_wr_data;
      end
      if (fire) begin
        phase        <= phase_next;
        header_count <= header_count_next;
        magic_match  <= magic_match_next;
        size_reg     <= size_reg_next;
        byte_offset  <= byte_offset_next;
        prog_cnt     <= prog_cnt_next;
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_ch.mem_write  <= r_write;
      out_ch.mem_addr   <= r_addr;
      out_ch.mem_data   <= r_data;
      out_ch.progress   <= r_prog;
      out_ch.status     <= r_status;
      out_ch.image_size <= r_size;
      out_ch.done_res   <= r_done;
    end
  end

endmodule

// ===== rtl/core/serial_boot_image_loader_core.sv =====
// ----------------------------------------------------------------------------
// serial_boot_image_loader_core
// Parses a BOOT header from serial bytes and turns the image into writes.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per received byte (command 0) or an abort
//   (command 1). Eight header bytes give magic "BOOT" and a little-endian
//   size; each later byte yields a memory write at load_base plus offset.
//   out_ch returns exactly one result item for every input item, in order.
//   Write load_base via cfg_wr_en/cfg_wr_data only while idle (not enforced).
// Timing:
//   One item per cycle sustained while out_ch.ready stays high. An accepted
//   item is held in the queue, then its result is registered in the back
//   stage, whose state update (counters and address add) is combinational.
//   A two-entry queue parts the front from the back, and the result
//   register takes a new item in the same cycle its result is taken.
// Reset:
//   rst clears load_base, the header parser and both valid flags.
// Stall:
//   When out_ch.ready is low the result holds, the queue fills and in_ch.ready
//   drops once it holds two items; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module serial_boot_image_loader_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  sbl_in_if.sink      in_ch,
  sbl_out_if.source   out_ch
);

  logic           fq_valid;
  sbl_pkg::qent_t fq_data;
  logic           fq_ready;
  logic           qb_valid;
  sbl_pkg::qent_t qb_data;
  logic           qb_ready;

  sbl_front u_front (
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_rx_byte (in_ch.rx_byte),
    .in_ready   (in_ch.ready),
    .q_wr_valid (fq_valid),
    .q_wr_data  (fq_data),
    .q_wr_ready (fq_ready)
  );

  sbl_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fq_valid),
    .wr_data  (fq_data),
    .wr_ready (fq_ready),
    .rd_valid (qb_valid),
    .rd_data  (qb_data),
    .rd_ready (qb_ready)
  );

  sbl_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (qb_valid),
    .q_data      (qb_data),
    .q_ready     (qb_ready),
    .out_ch      (out_ch)
  );

  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> qb_valid)
    else $error("accepted item missing from queue");

  a_write_is_loading: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.mem_write) |-> (out_ch.status == sbl_pkg::ST_LOADING))
    else $error("memory write outside loading");

  a_abort_clean: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && (out_ch.status == sbl_pkg::ST_ABORTED)) |->
      (!out_ch.mem_write && !out_ch.done_res && !out_ch.progress &&
       (out_ch.image_size == 32'd0)))
    else $error("abort result carries data");

  a_abort_accept: assert property (@(posedge clk) disable iff (rst)
    (qb_valid && qb_ready && (qb_data.op == sbl_pkg::OP_ABORT)) |=>
      (out_ch.valid && (out_ch.status == sbl_pkg::ST_ABORTED)))
    else $error("abort not reported");

endmodule

// ===== verif/serial_boot_image_loader_core_tb.sv =====
// ----------------------------------------------------------------------------
// serial_boot_image_loader_core_tb
// Self-checking bench for the serial boot image loader core. Drives header,
// image, abort and noise items with random source gaps and sink stalls,
// predicts each result from a local model of the loader, and compares every
// result field against the oldest prediction.
// ----------------------------------------------------------------------------
module serial_boot_image_loader_core_tb;

  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic             mem_write;
    logic [31:0]      mem_addr;
    logic [7:0]       mem_data;
    logic             progress;
    sbl_pkg::status_t status;
    logic [31:0]      image_size;
    logic             done_res;
  } loader_result_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  sbl_in_if  in_ch();
  sbl_out_if out_ch();

  serial_boot_image_loader_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // loader model state
  logic [31:0]      load_base_q;
  sbl_pkg::phase_t  phase_q;
  logic [2:0]       hdr_cnt_q;
  logic             magic_ok_q;
  logic [31:0]      size_q;
  logic [31:0]      offset_q;

  loader_result_t pending_results[$];
  int unsigned    mismatch_count;
  int unsigned    items_sent;
  bit             no_idle;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void clear_loader();
    phase_q    = sbl_pkg::PH_HUNT;
    hdr_cnt_q  = '0;
    magic_ok_q = 1'b1;
    size_q     = '0;
    offset_q   = '0;
  endfunction

  function automatic loader_result_t predict_loader_result(sbl_pkg::op_t op,
                                                           logic [7:0] b);
    loader_result_t r;
    int unsigned    n;
    r = '0;
    if (op == sbl_pkg::OP_ABORT) begin
      clear_loader();
      r.status = sbl_pkg::ST_ABORTED;
      return r;
    end
    if (phase_q == sbl_pkg::PH_HUNT) begin
      n = hdr_cnt_q;
      if (n < sbl_pkg::MAGIC_BYTES) begin
        if (b != sbl_pkg::MAGIC[n]) magic_ok_q = 1'b0;
      end else begin
        size_q = size_q | (32'(b) << (8 * (n - sbl_pkg::MAGIC_BYTES)));
      end
      n++;
      if (n < sbl_pkg::HEADER_BYTES) begin
        hdr_cnt_q = n[2:0];
        r.status  = sbl_pkg::ST_HEADER;
        return r;
      end
      hdr_cnt_q = '0;
      if (!magic_ok_q) begin
        clear_loader();
        r.status = sbl_pkg::ST_BAD_MAGIC;
        return r;
      end
      r.status     = sbl_pkg::ST_GOOD_MAGIC;
      r.image_size = size_q;
      magic_ok_q   = 1'b1;
      offset_q     = '0;
      if (size_q == '0) begin
        r.done_res = 1'b1;
        clear_loader();
      end else begin
        phase_q = sbl_pkg::PH_LOAD;
      end
      return r;
    end
    r.mem_write = 1'b1;
    r.mem_addr  = load_base_q + offset_q;
    r.mem_data  = b;
    r.progress  = (offset_q % sbl_pkg::PROGRESS_INTERVAL) == 0;
    r.status    = sbl_pkg::ST_LOADING;
    offset_q    = offset_q + 32'd1;
    if (offset_q == size_q) begin
      r.done_res = 1'b1;
      clear_loader();
    end
    return r;
  endfunction

  function automatic void note_failure(string msg);
    if (mismatch_count < MAX_REPORTS) $display("%s", msg);
    mismatch_count++;
  endfunction

  always @(posedge clk) begin
    loader_result_t got;
    loader_result_t exp;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.mem_write  = out_ch.mem_write;
      got.mem_addr   = out_ch.mem_addr;
      got.mem_data   = out_ch.mem_data;
      got.progress   = out_ch.progress;
      got.status     = sbl_pkg::status_t'(out_ch.status);
      got.image_size = out_ch.image_size;
      got.done_res   = out_ch.done_res;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: st=%0d addr=%h", got.status,
                               got.mem_addr));
      end else begin
        exp = pending_results.pop_front();
        if (got !== exp)
          note_failure($sformatf({"mismatch: exp wr=%0b addr=%h data=%h prog=%0b st=%0d ",
                                  "size=%h done=%0b / got wr=%0b addr=%h data=%h prog=%0b ",
                                  "st=%0d size=%h done=%0b"},
                                 exp.mem_write, exp.mem_addr, exp.mem_data, exp.progress,
                                 exp.status, exp.image_size, exp.done_res,
                                 got.mem_write, got.mem_addr, got.mem_data, got.progress,
                                 got.status, got.image_size, got.done_res));
      end
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_item(sbl_pkg::op_t op, logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.command <= op;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_results.push_back(predict_loader_result(op, b));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_load_base(logic [31:0] v);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    load_base_q = v;
  endtask

  // bad_pos < 0 gives a good magic, else that magic byte is corrupted
  task automatic send_header(logic [31:0] size, int bad_pos);
    logic [7:0] b;
    if (phase_q != sbl_pkg::PH_HUNT || hdr_cnt_q != '0)
      send_item(sbl_pkg::OP_ABORT, 8'($urandom_range(0, 255)));
    for (int i = 0; i < sbl_pkg::MAGIC_BYTES; i++) begin
      b = sbl_pkg::MAGIC[i];
      if (i == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      send_item(sbl_pkg::OP_BYTE, b);
    end
    for (int i = 0; i < 4; i++) send_item(sbl_pkg::OP_BYTE, size[8*i +: 8]);
  endtask

  task automatic send_image_bytes(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_item(sbl_pkg::OP_BYTE, 8'($urandom_range(0, 255)));
  endtask

  task automatic test_good_image_wrap();
    set_load_base(32'hFFFF_FFFF);
    send_header(32'd3, -1);
    send_item(sbl_pkg::OP_BYTE, 8'h00);
    send_item(sbl_pkg::OP_BYTE, 8'hFF);
    set_load_base(32'h0000_0000);
    send_item(sbl_pkg::OP_BYTE, 8'hA5);
  endtask

  task automatic test_zero_and_bad_header();
    send_header(32'd0, -1);
    send_header(32'hFFFF_FFFF, 3);
  endtask

  task automatic test_abort();
    send_item(sbl_pkg::OP_BYTE, 8'h42);
    send_item(sbl_pkg::OP_BYTE, 8'h4F);
    send_item(sbl_pkg::OP_ABORT, 8'hFF);
  endtask

  task automatic test_progress_mark();
    no_idle = 1'b0;
    set_load_base(32'($urandom));
    send_header(32'd1026, -1);
    send_image_bytes(1026);
  endtask

  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned len;
    logic [31:0] sz;
    while (items_sent < ITEM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 19);
      if (pick < 12) begin
        sz = $urandom_range(1, 48);
        send_header(sz, -1);
        send_image_bytes(sz);
      end else if (pick < 14) begin
        sz = $urandom_range(2, 64);
        send_header(sz, -1);
        send_image_bytes($urandom_range(0, sz - 1));
        send_item(sbl_pkg::OP_ABORT, 8'($urandom_range(0, 255)));
      end else if (pick < 15) begin
        sz = 32'($urandom) | 32'h0000_0100;
        send_header(sz, -1);
        send_image_bytes($urandom_range(0, 12));
        send_item(sbl_pkg::OP_ABORT, 8'($urandom_range(0, 255)));
      end else if (pick < 17) begin
        send_header(32'($urandom), $urandom_range(0, 3));
      end else if (pick < 18) begin
        len = $urandom_range(1, 10);
        for (int unsigned i = 0; i < len; i++)
          send_item(($urandom_range(0, 5) == 0) ? sbl_pkg::OP_ABORT : sbl_pkg::OP_BYTE,
                    8'($urandom_range(0, 255)));
      end else if (pick < 19) begin
        send_header(32'd0, -1);
      end else begin
        case ($urandom_range(0, 3))
          0:       set_load_base(32'h0000_0000);
          1:       set_load_base(32'hFFFF_FFFF);
          2:       set_load_base(32'hFFFF_FF00 | 32'($urandom_range(0, 255)));
          default: set_load_base(32'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = sbl_pkg::OP_BYTE;
    in_ch.rx_byte = '0;
    no_idle       = 1'b0;
    load_base_q   = '0;
    clear_loader();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_good_image_wrap();
    test_zero_and_bad_header();
    test_abort();
    test_progress_mark();
    test_random_traffic();

    drain_results();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("serial_boot_image_loader_core regression: pass");
    end else begin
      $display("serial_boot_image_loader_core regression: fail");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("serial_boot_image_loader_core regression: fail");
    $finish;
  end

endmodule
